@@ sv/rsa_pkg.sv @@
// shared constants, types and tables for the relu/softmax activation block
`timescale 1ns / 1ps

package rsa_pkg;

  localparam int MaxElements = 64;
  localparam int CntW        = $clog2(MaxElements + 1);
  localparam int IdxW        = (MaxElements > 1) ? $clog2(MaxElements) : 1;
  localparam int ExpW        = 28;
  localparam int SumW        = ExpW + CntW - 1;
  localparam int NumW        = ExpW + 16;
  localparam int QuoW        = NumW;

  localparam logic MODE_RELU    = 1'b0;
  localparam logic MODE_SOFTMAX = 1'b1;

  // commands from controller to datapath
  typedef struct packed {
    logic store;      // write exponential of the request at count
    logic drop;       // set dropped flag
    logic rd_start;   // read store entry and start divide
    logic clear;      // end of vector
  } rsa_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic             full;
    logic [CntW-1:0]  count;
    logic             div_done;
  } rsa_sts_t;

  function automatic logic [26:0] int_exp(input logic [3:0] k);
    logic [26:0] r;
    case (k)
      4'd0:    r = 27'd22;
      4'd1:    r = 27'd60;
      4'd2:    r = 27'd162;
      4'd3:    r = 27'd442;
      4'd4:    r = 27'd1200;
      4'd5:    r = 27'd3263;
      4'd6:    r = 27'd8869;
      4'd7:    r = 27'd24109;
      4'd8:    r = 27'd65536;
      4'd9:    r = 27'd178145;
      4'd10:   r = 27'd484250;
      4'd11:   r = 27'd1316326;
      4'd12:   r = 27'd3578144;
      4'd13:   r = 27'd9726405;
      4'd14:   r = 27'd26439109;
      4'd15:   r = 27'd71868951;
      default: r = 27'd0;
    endcase
    return r;
  endfunction

  function automatic logic [17:0] frac_exp(input logic [4:0] i);
    logic [17:0] r;
    case (i)
      5'd0:    r = 18'd65536;
      5'd1:    r = 18'd69763;
      5'd2:    r = 18'd74262;
      5'd3:    r = 18'd79052;
      5'd4:    r = 18'd84150;
      5'd5:    r = 18'd89577;
      5'd6:    r = 18'd95354;
      5'd7:    r = 18'd101504;
      5'd8:    r = 18'd108051;
      5'd9:    r = 18'd115019;
      5'd10:   r = 18'd122437;
      5'd11:   r = 18'd130334;
      5'd12:   r = 18'd138740;
      5'd13:   r = 18'd147688;
      5'd14:   r = 18'd157213;
      5'd15:   r = 18'd167352;
      5'd16:   r = 18'd178145;
      default: r = 18'd0;
    endcase
    return r;
  endfunction

endpackage

@@ sv/rsa_in_if.sv @@
// input request channel: element value and last marker
`timescale 1ns / 1ps

interface rsa_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] value;
  logic               last;

  modport source (output valid, value, last, input ready);
  modport sink   (input valid, value, last, output ready);
endinterface

@@ sv/rsa_out_if.sv @@
// output request channel: result, last marker and overflow flag
`timescale 1ns / 1ps

interface rsa_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] result;
  logic        last_out;
  logic        overflow;

  modport source (output valid, result, last_out, overflow, input ready);
  modport sink   (input valid, result, last_out, overflow, output ready);
endinterface

@@ sv/rsa_exp.sv @@
// two-stage fixed-point exponential: interpolation, then scaling by exp(k - 8)
`timescale 1ns / 1ps

module rsa_exp (
  input  logic                 clk_i,
  input  logic [15:0]          value_i,
  output logic [rsa_pkg::ExpW-1:0] exp_o
);
  import rsa_pkg::*;

  logic [15:0] u;
  logic [17:0] lo, hi, diff;
  logic [25:0] prod_w;
  logic [17:0] fr_d, fr_q;
  logic [3:0]  k_q;
  logic [44:0] p;

  // offset to unsigned code, interpolate fraction
  always_comb begin
    u      = value_i + 16'h8000;
    lo     = frac_exp({1'b0, u[11:8]});
    hi     = frac_exp({1'b0, u[11:8]} + 5'd1);
    diff   = hi - lo;
    prod_w = diff * {18'd0, u[7:0]};
    fr_d   = lo + 18'((prod_w + 26'd128) >> 8);
  end

  always_ff @(posedge clk_i) begin
    fr_q <= fr_d;
    k_q  <= u[15:12];
  end

  // scale by integer exponential, round half up
  always_comb begin
    p     = int_exp(k_q) * fr_q + 45'd32768;
    exp_o = p[16 +: ExpW];
  end

endmodule

@@ sv/rsa_div.sv @@
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module rsa_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [rsa_pkg::NumW-1:0] num_i,
  input  logic [rsa_pkg::SumW-1:0] den_i,
  output logic                     done_o,
  output logic [15:0]              quo_o
);
  import rsa_pkg::*;

  localparam int StepW = $clog2(NumW + 1);

  logic [NumW-1:0]  quo_q, quo_d;
  logic [SumW:0]    rem_q, rem_d;
  logic [SumW-1:0]  den_q;
  logic [StepW-1:0] step_q, step_d;
  logic             busy_q, busy_d, done_q, done_d;
  logic [SumW+1:0]  trial;

  // shift in next numerator bit, subtract when it fits
  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = '0;
    if (start_i) begin
      quo_d  = num_i;
      rem_d  = '0;
      step_d = StepW'(NumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      trial = {rem_q, quo_q[NumW-1]};
      if (trial >= {2'b0, den_q}) begin
        trial = trial - {2'b0, den_q};
        quo_d = {quo_q[NumW-2:0], 1'b1};
      end else begin
        quo_d = {quo_q[NumW-2:0], 1'b0};
      end
      rem_d  = trial[SumW:0];
      step_d = step_q - 1'b1;
      if (step_q == StepW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) den_q <= den_i;
  end

  // saturate to sixteen bits
  assign done_o = done_q;
  assign quo_o  = (|quo_q[NumW-1:16]) ? 16'hFFFF : quo_q[15:0];

endmodule

@@ sv/rsa_datapath.sv @@
// softmax datapath: exponential store, sum, count, flag and divider
`timescale 1ns / 1ps

module rsa_datapath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [15:0]           value_i,
  input  rsa_pkg::rsa_cmd_t     cmd_i,
  input  logic [rsa_pkg::IdxW-1:0] rd_idx_i,
  output rsa_pkg::rsa_sts_t     sts_o,
  output logic [15:0]           prob_o,
  output logic                  dropped_o
);
  import rsa_pkg::*;

  logic [ExpW-1:0] exp_store [MaxElements];
  logic [ExpW-1:0] exp_w, rd_q;
  logic [SumW-1:0] sum_q;
  logic [CntW-1:0] cnt_q;
  logic            drop_q;
  logic            rd_go_q;
  logic            div_done;

  rsa_exp u_exp (.clk_i(clk_i), .value_i(value_i), .exp_o(exp_w));

  // store write and registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.store) exp_store[cnt_q[IdxW-1:0]] <= exp_w;
    rd_q <= exp_store[rd_idx_i];
  end

  // sum, count and drop flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      cnt_q   <= '0;
      drop_q  <= 1'b0;
      rd_go_q <= 1'b0;
    end else begin
      rd_go_q <= cmd_i.rd_start;
      if (cmd_i.clear) begin
        sum_q  <= '0;
        cnt_q  <= '0;
        drop_q <= 1'b0;
      end else begin
        if (cmd_i.store) begin
          sum_q <= sum_q + SumW'(exp_w);
          cnt_q <= cnt_q + 1'b1;
        end
        if (cmd_i.drop) drop_q <= 1'b1;
      end
    end
  end

  rsa_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (rd_go_q),
    .num_i   ({rd_q, 16'd0} + NumW'(sum_q >> 1)),
    .den_i   (sum_q),
    .done_o  (div_done),
    .quo_o   (prob_o)
  );

  assign sts_o.full     = (cnt_q == CntW'(MaxElements));
  assign sts_o.count    = cnt_q;
  assign sts_o.div_done = div_done;
  assign dropped_o      = drop_q;

endmodule

@@ sv/rsa_ctrl.sv @@
// controller: request intake, ReLU result, exponential wait, per-element divide and emit
`timescale 1ns / 1ps

module rsa_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     mode_i,
  rsa_in_if.sink                   in_if,
  rsa_out_if.source                out_if,
  input  rsa_pkg::rsa_sts_t        sts_i,
  input  logic [15:0]              prob_i,
  input  logic                     dropped_i,
  output rsa_pkg::rsa_cmd_t        cmd_o,
  output logic [rsa_pkg::IdxW-1:0] rd_idx_o,
  output logic [15:0]              value_o
);
  import rsa_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_EXP, S_RD, S_DIV, S_OUT
  } state_e;

  state_e          state_q;
  logic            last_q;
  logic [CntW-1:0] j_q;
  logic            ovalid_q, olast_q, oflow_q;
  logic [15:0]     ores_q;
  logic            take;

  assign in_if.ready = (state_q == S_IDLE) && !ovalid_q;
  assign take        = in_if.valid && in_if.ready;
  // exponential first stage runs on the request as it is offered
  assign value_o     = in_if.value;
  assign rd_idx_o    = j_q[IdxW-1:0];

  // command decode
  always_comb begin
    cmd_o          = '0;
    cmd_o.store    = (state_q == S_EXP) && !sts_i.full;
    cmd_o.drop     = (state_q == S_EXP) && sts_i.full;
    cmd_o.rd_start = (state_q == S_RD);
    cmd_o.clear    = (state_q == S_OUT);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ovalid_q <= 1'b0;
      j_q      <= '0;
      last_q   <= 1'b0;
      ores_q   <= '0;
      olast_q  <= 1'b0;
      oflow_q  <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) ovalid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (take) begin
            last_q <= in_if.last;
            if (mode_i == MODE_RELU) begin
              ovalid_q <= 1'b1;
              ores_q   <= in_if.value[15] ? 16'd0 : in_if.value;
              olast_q  <= in_if.last;
              oflow_q  <= 1'b0;
            end else begin
              state_q <= S_EXP;
            end
          end
        end
        S_EXP: begin
          j_q <= '0;
          // a last element always leaves at least one stored entry
          if (!last_q) begin
            state_q <= S_IDLE;
          end else begin
            state_q <= S_RD;
          end
        end
        S_RD: begin
          if (!ovalid_q || (out_if.valid && out_if.ready)) state_q <= S_DIV;
          else state_q <= S_RD;
        end
        S_DIV: begin
          if (sts_i.div_done) begin
            ovalid_q <= 1'b1;
            ores_q   <= prob_i;
            olast_q  <= (j_q + 1'b1 == sts_i.count);
            oflow_q  <= dropped_i;
            j_q      <= j_q + 1'b1;
            if (j_q + 1'b1 == sts_i.count) state_q <= S_OUT;
            else state_q <= S_RD;
          end
        end
        S_OUT: begin
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_if.valid    = ovalid_q;
  assign out_if.result   = ores_q;
  assign out_if.last_out = olast_q;
  assign out_if.overflow = oflow_q;

endmodule

@@ sv/relu_softmax_activation.sv @@
// ReLU: result registered the next cycle after intake; no new request is taken
// while a result waits. softmax element: intake, then the exponential stage; after
// the last element each probability is divided by the bit-serial divider, then sent.
// store has no reset; count, sum, drop flag and mode reset to zero asynchronously.
// the store is read every cycle; only entries written during the current vector reach the divider.
`timescale 1ns / 1ps

module relu_softmax_activation (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic      cfg_wdata_i,
  rsa_in_if.sink    in_if,
  rsa_out_if.source out_if
);
  import rsa_pkg::*;

  logic            mode_q;
  rsa_cmd_t        cmd;
  rsa_sts_t        sts;
  logic [15:0]     prob, value;
  logic            dropped;
  logic [IdxW-1:0] rd_idx;

  // mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) mode_q <= MODE_RELU;
    else if (cfg_we_i) mode_q <= cfg_wdata_i;
  end

  rsa_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .mode_i    (mode_q),
    .in_if     (in_if),
    .out_if    (out_if),
    .sts_i     (sts),
    .prob_i    (prob),
    .dropped_i (dropped),
    .cmd_o     (cmd),
    .rd_idx_o  (rd_idx),
    .value_o   (value)
  );

  rsa_datapath u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .value_i   (value),
    .cmd_i     (cmd),
    .rd_idx_i  (rd_idx),
    .sts_o     (sts),
    .prob_o    (prob),
    .dropped_o (dropped)
  );

endmodule

@@ dv/relu_softmax_activation_tb.sv @@
// testbench for the relu/softmax activation block: directed and random vectors checked against a predictor
`timescale 1ns / 1ps

module relu_softmax_activation_tb;
  import rsa_pkg::*;

  typedef struct packed {
    logic signed [15:0] value;
    logic               last;
  } elem_t;

  typedef struct packed {
    logic [15:0] result;
    logic        last_out;
    logic        overflow;
  } prob_t;

  localparam int CycleLimit = 200000;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_wdata_i;

  rsa_in_if  in_ch ();
  rsa_out_if out_ch ();

  relu_softmax_activation uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_if       (in_ch.sink),
    .out_if      (out_ch.source)
  );

  // predictor state
  logic        act_mode;
  logic [27:0] exp_mem [MaxElements];
  logic [63:0] exp_total;
  int          stored_cnt;
  logic        drop_seen;

  elem_t pending_q [$];
  prob_t expected_q [$];
  int    err_cnt;
  int    res_cnt;
  int    softmax_vecs;
  int    idle_cnt;
  bit    stim_done;
  bit    calm;
  int    hold_long;

  // table lookups written out independently of the package helpers
  function automatic logic [31:0] exp_int_lut(input logic [3:0] k);
    logic [31:0] t [16];
    t = '{22, 60, 162, 442, 1200, 3263, 8869, 24109, 65536, 178145, 484250,
          1316326, 3578144, 9726405, 26439109, 71868951};
    return t[k];
  endfunction

  function automatic logic [31:0] exp_frac_lut(input logic [4:0] i);
    logic [31:0] t [17];
    t = '{65536, 69763, 74262, 79052, 84150, 89577, 95354, 101504, 108051,
          115019, 122437, 130334, 138740, 147688, 157213, 167352, 178145};
    return t[i];
  endfunction

  // piecewise exponential in Q12.16
  function automatic logic [27:0] exp_q12_16(input logic [15:0] raw);
    logic [15:0] u;
    logic [31:0] lo, hi, fr;
    logic [63:0] p;
    u  = raw + 16'h8000;
    lo = exp_frac_lut({1'b0, u[11:8]});
    hi = exp_frac_lut({1'b0, u[11:8]} + 5'd1);
    fr = lo + (((hi - lo) * u[7:0] + 32'd128) >> 8);
    p  = 64'(exp_int_lut(u[15:12])) * fr + 64'd32768;
    return p[43:16];
  endfunction

  // work out results for one accepted request
  task automatic predict_activation(input elem_t e);
    logic [63:0] q;
    prob_t r;
    if (act_mode == MODE_RELU) begin
      r.result   = e.value[15] ? 16'd0 : e.value;
      r.last_out = e.last;
      r.overflow = 1'b0;
      expected_q.push_back(r);
      return;
    end
    if (stored_cnt < MaxElements) begin
      exp_mem[stored_cnt] = exp_q12_16(e.value);
      exp_total += exp_mem[stored_cnt];
      stored_cnt++;
    end else begin
      drop_seen = 1'b1;
    end
    if (!e.last) return;
    for (int j = 0; j < stored_cnt; j++) begin
      q = (({36'd0, exp_mem[j]} << 16) + (exp_total >> 1)) / exp_total;
      r.result   = (q > 64'hFFFF) ? 16'hFFFF : q[15:0];
      r.last_out = (j + 1 == stored_cnt);
      r.overflow = drop_seen;
      expected_q.push_back(r);
    end
    softmax_vecs++;
    stored_cnt = 0;
    exp_total  = 0;
    drop_seen  = 1'b0;
  endtask

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    err_cnt++;
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // driver: offers pending requests with random gaps
  int gap_left;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      in_ch.value <= '0;
      in_ch.last  <= 1'b0;
      gap_left    = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_activation('{in_ch.value, in_ch.last});
        void'(pending_q.pop_front());
      end
      if (!(in_ch.valid && !in_ch.ready)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (pending_q.size() > 0) begin
          in_ch.valid <= 1'b1;
          in_ch.value <= pending_q[0].value;
          in_ch.last  <= pending_q[0].last;
          if (!calm && $urandom_range(0, 5) == 0) gap_left = $urandom_range(1, 16);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: random back-pressure and result checks
  int stall_left;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      stall_left   = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        res_cnt++;
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result", out_ch.result, 16'd0);
        end else begin
          if (out_ch.result !== expected_q[0].result)
            report_mismatch("result", out_ch.result, expected_q[0].result);
          if (out_ch.last_out !== expected_q[0].last_out)
            report_mismatch("last_out", 16'(out_ch.last_out),
                            16'(expected_q[0].last_out));
          if (out_ch.overflow !== expected_q[0].overflow)
            report_mismatch("overflow", 16'(out_ch.overflow),
                            16'(expected_q[0].overflow));
          void'(expected_q.pop_front());
        end
      end
      if (hold_long > 0) begin
        hold_long--;
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if (!calm && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 16);
      end
    end
  end

  // watchdog on cycles with no handshake on either channel
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_ni)
      idle_cnt <= 0;
    else
      idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= CycleLimit) begin
      $display("relu_softmax_activation_tb: done, errors");
      $finish;
    end
  end

  task automatic push_elem(input logic [15:0] v, input logic l);
    elem_t e;
    e.value = v;
    e.last  = l;
    pending_q.push_back(e);
  endtask

  // wait until everything drains, then settle the divider before a mode write
  task automatic drain_and_set_mode(input logic m);
    while (pending_q.size() > 0 || in_ch.valid || expected_q.size() > 0)
      @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    act_mode = m;
    cfg_we_i <= 1'b0;
  endtask

  task automatic push_vector(input int len, input bit wild);
    logic [15:0] v;
    for (int i = 0; i < len; i++) begin
      if (wild) v = 16'($urandom);
      else v = 16'($urandom_range(0, 65535) % 16384 - 8192);
      push_elem(v, i == len - 1);
    end
  endtask

  initial begin
    int n;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = 1'b0;
    act_mode     = MODE_RELU;
    exp_total    = 0;
    stored_cnt   = 0;
    drop_seen    = 1'b0;
    err_cnt      = 0;
    res_cnt      = 0;
    softmax_vecs = 0;
    idle_cnt     = 0;
    stim_done    = 1'b0;
    calm         = 1'b0;
    hold_long    = 0;
    rst_ni       = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // relu extremes
    push_elem(16'h8000, 1'b0);
    push_elem(16'h7FFF, 1'b1);
    push_elem(16'h0000, 1'b0);
    push_elem(16'hFFFF, 1'b1);
    push_elem(16'h5555, 1'b0);
    push_elem(16'hAAAA, 1'b0);
    drain_and_set_mode(MODE_SOFTMAX);
    // single element, extremes, then a vector with last on a dropped element
    push_elem(16'h8000, 1'b1);
    push_elem(16'h7FFF, 1'b0);
    push_elem(16'h8000, 1'b0);
    push_elem(16'h0000, 1'b1);
    for (int i = 0; i < MaxElements + 2; i++)
      push_elem(16'($urandom), i == MaxElements + 1);
    // mode change mid-vector keeps gathered elements
    push_elem(16'h1000, 1'b0);
    drain_and_set_mode(MODE_RELU);
    push_elem(16'hC000, 1'b1);
    drain_and_set_mode(MODE_SOFTMAX);
    push_elem(16'hF000, 1'b1);

    // long receiver hold-off while a full vector and more requests are offered
    hold_long = 400;
    push_vector(MaxElements, 1'b1);
    push_vector(8, 1'b0);

    // random phases over both modes
    for (int ph = 0; ph < 8; ph++) begin
      drain_and_set_mode(ph[0]);
      if (ph == 6) calm = 1'b1;
      n = 0;
      while (n < 32) begin
        if (act_mode == MODE_RELU) begin
          push_elem(16'($urandom), 1'($urandom_range(0, 1)));
          n++;
        end else begin
          int len;
          len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 8);
          push_vector(len, $urandom_range(0, 3) != 0);
          n += len;
        end
      end
    end
    drain_and_set_mode(MODE_RELU);
    stim_done = 1'b1;

    $display("covered %0d results, %0d softmax vectors, capacity overflow and mode toggles",
             res_cnt, softmax_vecs);
    if (err_cnt == 0) begin
      $display("relu_softmax_activation_tb: done, clean");
    end else begin
      $display("relu_softmax_activation_tb: done, errors");
    end
    $finish;
  end

endmodule

@@ relu_softmax_activation.f @@
sv/rsa_pkg.sv
sv/rsa_in_if.sv
sv/rsa_out_if.sv
sv/rsa_exp.sv
sv/rsa_div.sv
sv/rsa_datapath.sv
sv/rsa_ctrl.sv
sv/relu_softmax_activation.sv
dv/relu_softmax_activation_tb.sv
